/* design/ngt_pkg.sv */
// Shared types and constants of the n-gram tokenizer.
`default_nettype none

package ngt_pkg;

  localparam int CP_W      = 21;  // code point width
  localparam int POS_W     = 32;  // position counter width
  localparam int LEN_W     = 3;   // token length / token count width
  localparam int TOK_CHARS = 4;   // code point slots in one result word

  typedef logic [CP_W-1:0]  cp_t;
  typedef cp_t [TOK_CHARS-1:0] tok_chars_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [POS_W-1:0] pos_t;

  // Step record handed from the front end to the emitter.
  typedef struct packed {
    logic       load;   // record is loaded this cycle
    tok_chars_t chars;  // characters of the first token, zero past len
    len_t       len;    // length of the first token
    pos_t       pos;    // position of the first token
    len_t       ntok;   // number of tokens to emit
  } rec_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_NGRAM_SIZE    = 1'b0,
    REG_INDEXING_MODE = 1'b1
  } reg_idx_t;

endpackage

`default_nettype wire

/* design/ngt_stream_if.sv */
// Stream interfaces for the character input and the token output channels.
`default_nettype none

interface ngt_in_if import ngt_pkg::*; ();
  logic valid;
  logic ready;
  cp_t  char_code;
  logic end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface ngt_out_if import ngt_pkg::*; ();
  logic valid;
  logic ready;
  cp_t  token_char0;
  cp_t  token_char1;
  cp_t  token_char2;
  cp_t  token_char3;
  len_t token_length;
  pos_t token_position;
  logic last_of_run;

  modport source (output valid, output token_char0, output token_char1,
                  output token_char2, output token_char3, output token_length,
                  output token_position, output last_of_run, input ready);
  modport sink   (input valid, input token_char0, input token_char1,
                  input token_char2, input token_char3, input token_length,
                  input token_position, input last_of_run, output ready);
endinterface

`default_nettype wire

/* design/ngt_cell.sv */
// One code point cell: parallel load or shift from the neighbor.
`default_nettype none

module ngt_cell import ngt_pkg::*; (
  input  logic clk,
  input  logic load,
  input  cp_t  load_d,
  input  logic shift,
  input  cp_t  shift_d,
  output cp_t  q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_d;
    end else if (shift) begin
      q <= shift_d;
    end
  end

endmodule

`default_nettype wire

/* design/ngt_front.sv */
// Tokenizer front end: separator check, window cells, step record build.
`default_nettype none

module ngt_front import ngt_pkg::*; #(
  parameter int CAP = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  cp_t        char_code,
  input  logic       end_of_text,
  input  logic [2:0] ngram_size,
  input  logic       indexing_mode,
  input  logic       size_wr,
  output rec_t       rec
);

  logic [1:0] count;
  logic [1:0] count_next;
  pos_t       start;
  pos_t       start_next;
  cp_t        win   [CAP];
  cp_t        win_d [CAP];
  cp_t        w4    [TOK_CHARS];
  cp_t        r     [TOK_CHARS];
  len_t       n;
  len_t       cnt_a;
  len_t       ln;
  len_t       ntok;
  logic       sep;
  logic       full;
  logic       flush;
  logic       keep;

  function automatic logic is_sep(cp_t c);
    logic s;
    s = 1'b0;
    if (c == 21'h20 || (c >= 21'h09 && c <= 21'h0D)) s = 1'b1;
    if ((c >= 21'h21 && c <= 21'h2F) || (c >= 21'h3A && c <= 21'h40) ||
        (c >= 21'h5B && c <= 21'h60) || (c >= 21'h7B && c <= 21'h7E)) s = 1'b1;
    // full-width space, comma, stop and punctuation marks
    if (c == 21'h3000 || c == 21'h3001 || c == 21'h3002 ||
        c == 21'hFF08 || c == 21'hFF09 || c == 21'hFF01 ||
        c == 21'hFF0C || c == 21'hFF1A || c == 21'hFF1B || c == 21'hFF1F) s = 1'b1;
    return s;
  endfunction

  // window cells; tail slots past CAP read as zero
  for (genvar i = 0; i < CAP; i++) begin : g_win
    ngt_cell u_cell (
      .clk     (clk),
      .load    (accept),
      .load_d  (win_d[i]),
      .shift   (1'b0),
      .shift_d ('0),
      .q       (win[i])
    );
  end

  for (genvar i = 0; i < TOK_CHARS; i++) begin : g_w4
    if (i < CAP) begin : g_cell
      assign w4[i] = win[i];
    end else begin : g_zero
      assign w4[i] = '0;
    end
  end

  // effective n: 0 acts as 1, clamp to CAP
  always_comb begin
    if (ngram_size == 3'd0) begin
      n = len_t'(1);
    end else if (ngram_size > len_t'(CAP)) begin
      n = len_t'(CAP);
    end else begin
      n = ngram_size;
    end
  end

  always_comb begin
    sep   = is_sep(char_code);
    cnt_a = len_t'(count);
    for (int i = 0; i < TOK_CHARS; i++) begin
      if (len_t'(i) < cnt_a) begin
        r[i] = w4[i];
      end else if (!sep && len_t'(i) == cnt_a) begin
        r[i] = char_code;
      end else begin
        r[i] = '0;
      end
    end
    ln    = cnt_a + len_t'(!sep);
    full  = !sep && (ln == n);
    flush = sep || end_of_text;
    keep  = flush && indexing_mode;
    ntok  = keep ? ln : len_t'(full);

    // full token retires the oldest character: window moves down one cell
    for (int i = 0; i < CAP; i++) begin
      win_d[i] = r[i];
      if (full) begin
        win_d[i] = (i < TOK_CHARS - 1) ? r[(i + 1) % TOK_CHARS] : '0;
      end
    end

    if (flush) begin
      count_next = 2'd0;
    end else if (full) begin
      count_next = 2'(n - len_t'(1));
    end else begin
      count_next = 2'(ln);
    end

    // flush uses up every pending position, full token or not; end of text restarts at 0
    if (end_of_text) begin
      start_next = '0;
    end else if (flush) begin
      start_next = start + POS_W'(ln);
    end else begin
      start_next = start + POS_W'(full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      start <= '0;
    end else if (size_wr) begin
      start <= start + POS_W'(count);
      count <= 2'd0;
    end else if (accept) begin
      count <= count_next;
      start <= start_next;
    end
  end

  always_comb begin
    rec.load = accept && (ntok != len_t'(0));
    for (int i = 0; i < TOK_CHARS; i++) begin
      rec.chars[i] = r[i];
    end
    rec.len  = ln;
    rec.pos  = start;
    rec.ntok = ntok;
  end

endmodule

`default_nettype wire

/* design/ngt_emit.sv */
// Token emitter: record cell chain shifted once per token, output register.
`default_nettype none

module ngt_emit import ngt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rec_t       rec,
  input  logic       out_ready,
  output logic       free,
  output logic       out_valid,
  output tok_chars_t out_chars,
  output len_t       out_len,
  output pos_t       out_pos,
  output logic       out_last
);

  cp_t  q [TOK_CHARS];
  len_t len;
  len_t rem;
  pos_t pos;
  logic emit;

  assign emit = (rem != len_t'(0)) && (!out_valid || out_ready);
  assign free = (rem == len_t'(0)) || (rem == len_t'(1) && emit);

  // next token drops the leading character: shift toward cell 0
  for (genvar i = 0; i < TOK_CHARS; i++) begin : g_rec
    cp_t sd;
    if (i < TOK_CHARS - 1) begin : g_nb
      assign sd = q[i+1];
    end else begin : g_end
      assign sd = '0;
    end
    ngt_cell u_cell (
      .clk     (clk),
      .load    (rec.load),
      .load_d  (rec.chars[i]),
      .shift   (emit),
      .shift_d (sd),
      .q       (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (rec.load) begin
      rem <= rec.ntok;
    end else if (emit) begin
      rem <= rem - len_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rec.load) begin
      len <= rec.len;
      pos <= rec.pos;
    end else if (emit) begin
      len <= len - len_t'(1);
      pos <= pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int i = 0; i < TOK_CHARS; i++) begin
        out_chars[i] <= q[i];
      end
      out_len  <= len;
      out_pos  <= pos;
      out_last <= (rem == len_t'(1));
    end
  end

endmodule

`default_nettype wire

/* design/ngram_tokenizer.sv */
// Character n-gram tokenizer top level: config registers, front end, emitter.
//
// Usage:
//  - in_ch takes one code point word per cycle while ready (char_code, end_of_text).
//  - out_ch gives one token word per cycle while ready: up to four code points,
//    length, position and last_of_run on the final token caused by an input word.
//  - APB port: ngram_size at 0x0, indexing_mode at 0x4; write only while
//    idle. Writing ngram_size drops the pending window, positions still count.
// Path: the first token of a word goes through the record chain, then the
//   output register, before it shows on out_ch.
// Throughput: one token word per cycle while out_ch.ready is high. A word
//   causing k tokens holds the emitter until its last token; in_ch.ready
//   rises again on the cycle that emits it, so plain characters stream at
//   one word per cycle unless out_ch stalls. A flush gives up to n tokens.
// Reset (rst, synchronous): window empty, position 0, no token pending,
//   ngram_size = 2, indexing_mode = 1.
// Receiver stall: the output register holds its token; the record chain
//   waits behind it, and in_ch.ready drops once the chain has work left.
`default_nettype none

module ngram_tokenizer import ngt_pkg::*; #(
  parameter int MAX_NGRAM = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ngt_in_if.sink      in_ch,
  ngt_out_if.source   out_ch
);

  localparam int CAP = (MAX_NGRAM < 4) ? MAX_NGRAM : 4;

  logic       [2:0] ngram_size;
  logic             indexing_mode;
  logic             cfg_wr;
  logic             size_wr;
  logic             accept;
  logic             free;
  rec_t             rec;
  tok_chars_t       out_chars;
  reg_idx_t         reg_sel;

  // APB: zero wait states, register index from the word address
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign size_wr = cfg_wr && (reg_sel == REG_NGRAM_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ngram_size    <= 3'd2;
      indexing_mode <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_NGRAM_SIZE:    ngram_size    <= pwdata[2:0];
        REG_INDEXING_MODE: indexing_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NGRAM_SIZE:    prdata = {29'd0, ngram_size};
      REG_INDEXING_MODE: prdata = {31'd0, indexing_mode};
      default:           prdata = '0;
    endcase
  end

  // input taken whenever the emitter can hold the next record
  assign in_ch.ready = free;
  assign accept      = in_ch.valid && free;

  ngt_front #(
    .CAP (CAP)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .char_code     (in_ch.char_code),
    .end_of_text   (in_ch.end_of_text),
    .ngram_size    (ngram_size),
    .indexing_mode (indexing_mode),
    .size_wr       (size_wr),
    .rec           (rec)
  );

  ngt_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec),
    .out_ready (out_ch.ready),
    .free      (free),
    .out_valid (out_ch.valid),
    .out_chars (out_chars),
    .out_len   (out_ch.token_length),
    .out_pos   (out_ch.token_position),
    .out_last  (out_ch.last_of_run)
  );

  assign out_ch.token_char0 = out_chars[0];
  assign out_ch.token_char1 = out_chars[1];
  assign out_ch.token_char2 = out_chars[2];
  assign out_ch.token_char3 = out_chars[3];

endmodule

`default_nettype wire

/* design/ngt_checker.sv */
// Port-level checker for the tokenizer, bound to the top level.
`default_nettype none

module ngt_checker import ngt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input cp_t  token_char1,
  input cp_t  token_char2,
  input cp_t  token_char3,
  input len_t token_length,
  input pos_t token_position
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_position))
    else $error("token word dropped or changed under stall");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_length != len_t'(0) && token_length <= len_t'(TOK_CHARS))
    else $error("token length out of range");

  a_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_length == len_t'(1) |->
      token_char1 == '0 && token_char2 == '0 && token_char3 == '0)
    else $error("unused code point slot not zero");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("token word valid right after reset");

endmodule

bind ngram_tokenizer ngt_checker u_ngt_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .token_char1    (out_ch.token_char1),
  .token_char2    (out_ch.token_char2),
  .token_char3    (out_ch.token_char3),
  .token_length   (out_ch.token_length),
  .token_position (out_ch.token_position)
);

`default_nettype wire
